// ===== rtl/kpscan_pkg.sv =====
// ----------------------------------------------------------------------------
// kpscan_pkg
// Types, register codes, reset values and the key table of the 4x4 keypad
// scanner.
// ----------------------------------------------------------------------------
package kpscan_pkg;

  localparam int unsigned CntW = 16;

  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_TIMEOUT  = 1'b1;

  localparam logic [CntW-1:0] DEBOUNCE_RESET = 16'd20;
  localparam logic [CntW-1:0] TIMEOUT_RESET  = 16'd30000;
  localparam logic [CntW-1:0] CNT_MAX        = 16'hFFFF;

  localparam logic [3:0] ROWS_IDLE = 4'hF;

  localparam logic [1:0] REQ_TICK      = 2'd0;
  localparam logic [1:0] REQ_START     = 2'd1;
  localparam logic [1:0] REQ_START_TMO = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_WAIT   = 3'd1,
    PH_DEBP   = 3'd2,
    PH_PROBE  = 3'd3,
    PH_PROBED = 3'd4,
    PH_WREL   = 3'd5,
    PH_DEBR   = 3'd6
  } phase_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] row_lines;
  } item_t;

  typedef struct packed {
    logic [CntW-1:0] debounce_ticks;
    logic [CntW-1:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [3:0] col_drive;
    logic       key_valid;
    logic [7:0] key_code;
    logic       timed_out;
    logic       busy_res;
  } result_t;

  // rows: '1' '2' '3' 'a' ; columns left to right
  localparam logic [7:0] KEY_TABLE [4][4] = '{
    '{8'h31, 8'h34, 8'h37, 8'h2A},
    '{8'h32, 8'h35, 8'h38, 8'h30},
    '{8'h33, 8'h36, 8'h39, 8'h23},
    '{8'h61, 8'h62, 8'h63, 8'h64}
  };

  function automatic logic [1:0] lowest_low_row(logic [3:0] rows);
    logic [1:0] idx;
    idx = 2'd0;
    priority casez (rows)
      4'b???0: idx = 2'd0;
      4'b??01: idx = 2'd1;
      4'b?011: idx = 2'd2;
      4'b0111: idx = 2'd3;
      default: idx = 2'd0;
    endcase
    return idx;
  endfunction

endpackage

// ===== rtl/kpscan_cfg.sv =====
// ----------------------------------------------------------------------------
// kpscan_cfg
// APB register file: debounce and timeout tick counts.
// ----------------------------------------------------------------------------
module kpscan_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output kpscan_pkg::cfg_t   cfg
);

  logic [kpscan_pkg::CntW-1:0] debounce_ticks;
  logic [kpscan_pkg::CntW-1:0] timeout_ticks;
  logic                        reg_sel;
  logic                        wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= kpscan_pkg::DEBOUNCE_RESET;
      timeout_ticks  <= kpscan_pkg::TIMEOUT_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        kpscan_pkg::REG_DEBOUNCE: debounce_ticks <= pwdata[kpscan_pkg::CntW-1:0];
        kpscan_pkg::REG_TIMEOUT:  timeout_ticks  <= pwdata[kpscan_pkg::CntW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      kpscan_pkg::REG_DEBOUNCE: prdata = {16'd0, debounce_ticks};
      kpscan_pkg::REG_TIMEOUT:  prdata = {16'd0, timeout_ticks};
      default:                  prdata = 32'd0;
    endcase
  end

  assign cfg.debounce_ticks = debounce_ticks;
  assign cfg.timeout_ticks  = timeout_ticks;

endmodule

// ===== rtl/kpscan_fsm.sv =====
// ----------------------------------------------------------------------------
// kpscan_fsm
// Scan state machine with debounce and wait counters; one tick per step.
// ----------------------------------------------------------------------------
module kpscan_fsm (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  kpscan_pkg::item_t     item,
  input  kpscan_pkg::cfg_t      cfg,
  output kpscan_pkg::result_t   result
);

  kpscan_pkg::phase_t          phase, phase_next;
  logic [1:0]                  found_row, found_row_next;
  logic [1:0]                  probe_column, probe_column_next;
  logic [kpscan_pkg::CntW-1:0] debounce_count, debounce_count_next;
  logic [kpscan_pkg::CntW-1:0] wait_count, wait_count_next;
  logic                        timeout_mode, timeout_mode_next;

  logic                        pressed;
  logic [kpscan_pkg::CntW-1:0] deb_lim;
  logic [kpscan_pkg::CntW-1:0] deb_inc;
  logic [kpscan_pkg::CntW-1:0] wait_inc;
  logic                        deb_done;
  logic                        tmo_hit;
  logic [3:0]                  col_sel;

  assign pressed  = item.row_lines != kpscan_pkg::ROWS_IDLE;
  assign deb_lim  = (cfg.debounce_ticks == '0) ? 16'd1 : cfg.debounce_ticks;
  assign deb_inc  = (debounce_count != kpscan_pkg::CNT_MAX) ? debounce_count + 16'd1
                                                            : debounce_count;
  assign wait_inc = (wait_count != kpscan_pkg::CNT_MAX) ? wait_count + 16'd1 : wait_count;
  assign deb_done = deb_inc >= deb_lim;
  assign tmo_hit  = timeout_mode && (wait_count >= cfg.timeout_ticks);

  // next state
  always_comb begin
    phase_next          = phase;
    found_row_next      = found_row;
    probe_column_next   = probe_column;
    debounce_count_next = debounce_count;
    wait_count_next     = wait_count;
    timeout_mode_next   = timeout_mode;
    unique case (phase)
      kpscan_pkg::PH_WAIT: begin
        if (tmo_hit) begin
          phase_next = kpscan_pkg::PH_IDLE;
        end else begin
          wait_count_next = wait_inc;
          if (pressed) begin
            debounce_count_next = '0;
            phase_next          = kpscan_pkg::PH_DEBP;
          end
        end
      end
      kpscan_pkg::PH_DEBP: begin
        wait_count_next     = wait_inc;
        debounce_count_next = deb_inc;
        if (deb_done) begin
          if (pressed) begin
            found_row_next    = kpscan_pkg::lowest_low_row(item.row_lines);
            probe_column_next = 2'd0;
            phase_next        = kpscan_pkg::PH_PROBE;
          end else begin
            phase_next = kpscan_pkg::PH_WAIT;
          end
        end
      end
      kpscan_pkg::PH_PROBE, kpscan_pkg::PH_PROBED: begin
        if (phase == kpscan_pkg::PH_PROBED) begin
          debounce_count_next = deb_inc;
        end
        if (phase == kpscan_pkg::PH_PROBE && pressed) begin
          debounce_count_next = '0;
          phase_next          = kpscan_pkg::PH_PROBED;
        end else if (phase == kpscan_pkg::PH_PROBED && deb_done && pressed) begin
          phase_next = kpscan_pkg::PH_WREL;
        end else if (phase == kpscan_pkg::PH_PROBE || deb_done) begin
          // no answer on this column: try the next one, restart after the last
          probe_column_next = probe_column + 2'd1;
          if (probe_column == 2'd3) begin
            wait_count_next = '0;
            phase_next      = kpscan_pkg::PH_WAIT;
          end else begin
            phase_next = kpscan_pkg::PH_PROBE;
          end
        end
      end
      kpscan_pkg::PH_WREL: begin
        if (!pressed) begin
          phase_next = kpscan_pkg::PH_IDLE;
        end else begin
          debounce_count_next = '0;
          phase_next          = kpscan_pkg::PH_DEBR;
        end
      end
      kpscan_pkg::PH_DEBR: begin
        debounce_count_next = deb_inc;
        if (deb_done) begin
          if (!pressed) begin
            phase_next = kpscan_pkg::PH_IDLE;
          end else begin
            debounce_count_next = '0;
          end
        end
      end
      default: begin
        phase_next = kpscan_pkg::PH_IDLE;
        if (item.req_type == kpscan_pkg::REQ_START ||
            item.req_type == kpscan_pkg::REQ_START_TMO) begin
          timeout_mode_next   = item.req_type == kpscan_pkg::REQ_START_TMO;
          wait_count_next     = '0;
          debounce_count_next = '0;
          probe_column_next   = 2'd0;
          phase_next          = kpscan_pkg::PH_WAIT;
        end
      end
    endcase
  end

  // outputs
  always_comb begin
    result.key_valid = 1'b0;
    result.timed_out = 1'b0;
    unique case (phase)
      kpscan_pkg::PH_WAIT: begin
        result.key_valid = tmo_hit;
        result.timed_out = tmo_hit;
      end
      kpscan_pkg::PH_WREL: result.key_valid = !pressed;
      kpscan_pkg::PH_DEBR: result.key_valid = deb_done && !pressed;
      default: ;
    endcase
    result.key_code = (result.key_valid && !result.timed_out)
                      ? kpscan_pkg::KEY_TABLE[found_row][probe_column] : 8'd0;
    col_sel = 4'b0001 << probe_column_next;
    result.col_drive = (phase_next == kpscan_pkg::PH_PROBE ||
                        phase_next == kpscan_pkg::PH_PROBED) ? ~col_sel : 4'h0;
    result.busy_res = phase_next != kpscan_pkg::PH_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= kpscan_pkg::PH_IDLE;
      found_row      <= '0;
      probe_column   <= '0;
      debounce_count <= '0;
      wait_count     <= '0;
      timeout_mode   <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      found_row      <= found_row_next;
      probe_column   <= probe_column_next;
      debounce_count <= debounce_count_next;
      wait_count     <= wait_count_next;
      timeout_mode   <= timeout_mode_next;
    end
  end

endmodule

// ===== rtl/matrix_keypad_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// matrix_keypad_scanner_unit
// 4x4 matrix keypad scanner: one row sample per stream transaction, one
// result per transaction.
// ----------------------------------------------------------------------------
// Each input transaction is one tick of the scanner and yields exactly one
// output transaction. A transaction is registered on entry; once the output
// register is free, the scan state machine processes it and its result lands
// in the output register. One transaction can be taken every clock cycle
// while the output is not stalled. Either side may stall at any time.
// Configuration registers (debounce at 0x0, timeout at 0x4) should only be
// written while no transaction is in flight.
module matrix_keypad_scanner_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [1:0] req_type, [5:2] row_lines, [7:6] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [3:0] col_drive, [4] key_valid, [12:5] key_code,
                                 // [13] timed_out, [14] busy_res, [15] zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  kpscan_pkg::cfg_t    cfg;
  kpscan_pkg::item_t   in_item;
  kpscan_pkg::result_t result;
  kpscan_pkg::result_t out_res;
  logic                in_valid;
  logic                advance;

  kpscan_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.req_type  <= s_tdata[1:0];
      in_item.row_lines <= s_tdata[5:2];
    end
  end

  kpscan_fsm u_fsm (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_item),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= result;
    end
  end

  assign m_tdata = {1'b0, out_res.busy_res, out_res.timed_out, out_res.key_code,
                    out_res.key_valid, out_res.col_drive};

`ifndef SYNTHESIS
  a_report_ends_scan: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.key_valid |-> !out_res.busy_res)
    else $error("key report while scan still busy");

  a_timeout_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.timed_out |-> out_res.key_valid && out_res.key_code == 8'd0)
    else $error("timeout report with bad flags or code");

  a_single_column: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_res.col_drive == 4'h0 || $countones(out_res.col_drive) == 3)
    else $error("more than one column driven low");

  a_input_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_item))
    else $error("stalled input transaction lost");
`endif

endmodule
